### rtl/fps_pkg.sv
`timescale 1ns / 1ps
package fps_pkg;

  localparam int unsigned WINDOW_DEF = 24;
  localparam int unsigned DVD_W      = 34;
  localparam int unsigned DSR_W      = 17;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_SHOW  = 2'd2;

  localparam logic [1:0] REG_FIRST    = 2'd0;
  localparam logic [1:0] REG_LAST     = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;
  localparam logic [1:0] REG_DROP     = 2'd3;

  typedef struct packed {
    logic capture;
    logic decode;
    logic n_done;
    logic modf_done;
    logic step_next;
    logic mode_done;
    logic record;
    logic pf_done;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       need_divn;
    logic       div_done;
    logic       wrap_f;
    logic       wrap_e;
    logic       adv_pos;
    logic       out_free;
  } dp_sts_t;

endpackage

### rtl/fps_ram.sv
`timescale 1ns / 1ps
module fps_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 24,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/fps_div.sv
`timescale 1ns / 1ps
module fps_div
  import fps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dvd_i,
  input  logic [DSR_W-1:0] dsr_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o,
  output logic [DSR_W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_q, q_d;
  logic [DSR_W-1:0] r_q, r_d, dsr_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DSR_W:0]   trial;

  always_comb begin
    q_d    = q_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {r_q, q_q[DVD_W-1]};
    if (start_i) begin
      q_d    = dvd_i;
      r_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        r_d = DSR_W'(trial - {1'b0, dsr_q});
        q_d = {q_q[DVD_W-2:0], 1'b1};
      end else begin
        r_d = trial[DSR_W-1:0];
        q_d = {q_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    if (start_i) begin
      dsr_q <= dsr_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

### rtl/fps_dp.sv
`timescale 1ns / 1ps
module fps_dp
  import fps_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF,
  localparam int unsigned FW = $clog2(WINDOW + 1),
  localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int unsigned IW = 16 + FW,
  localparam int unsigned PW = 20 + FW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic [1:0]    op_i,
  input  logic [31:0]   now_ms_i,
  input  logic [15:0]   frame_number_i,
  input  logic          out_stall_i,
  input  dp_cmd_t       cmd_i,
  output dp_sts_t       sts_o,
  output logic          out_valid_o,
  output logic [15:0]   shown_frame_o,
  output logic [15:0]   next_delay_ms_o,
  output logic [15:0]   frames_advanced_o,
  output logic          frame_dropped_o,
  output logic [IW-1:0] interval_sum_o,
  output logic [FW-1:0] interval_fill_o,
  output logic [FW-1:0] drop_count_o,
  output logic [PW-1:0] per_frame_sum_o,
  output logic [FW-1:0] per_frame_fill_o
);

  logic [15:0] first_q, last_q;
  logic [9:0]  ival_q;
  logic        drop_en_q;

  logic [1:0]  op_q;
  logic [31:0] now_q;
  logic [15:0] fnum_q;

  logic [15:0] expected_q, td_q, last_shown_q, frame_q, adv_q;
  logic [31:0] deadline_q, last_up_q;
  logic        seen_q, drop_q;
  logic [AW-1:0] iv_ptr_q, pf_ptr_q;
  logic [FW-1:0] iv_fill_q, pf_fill_q;
  logic [IW-1:0] isum_q;
  logic [FW-1:0] dcnt_q;
  logic [PW-1:0] psum_q;

  logic        out_valid_q;
  logic [15:0] o_shown_q, o_delay_q, o_adv_q;
  logic        o_drop_q;
  logic [IW-1:0] o_isum_q;
  logic [FW-1:0] o_ifill_q, o_dcnt_q, o_pfill_q;
  logic [PW-1:0] o_psum_q;

  logic [9:0]  iv_eff;
  logic [15:0] last_eff;
  logic [16:0] len;
  logic [31:0] diff;
  logic signed [34:0] tv;
  logic [15:0] td_tick;
  logic [DVD_W-1:0] s_f;
  logic [16:0] s_e;
  logic [31:0] el32;
  logic [15:0] el;
  logic [17:0] dwrap;
  logic [15:0] dval;
  logic        div_start, div_done;
  logic [DVD_W-1:0] div_dvd, quot;
  logic [DSR_W-1:0] div_dsr, rem;
  logic [16:0] iv_rd;
  logic [19:0] pf_rd;
  logic        iv_full, pf_full, iv_we, pf_we;
  logic [15:0] old_el;
  logic        old_drop;

  assign iv_eff   = (ival_q == 10'd0) ? 10'd1 : ival_q;
  assign last_eff = (last_q < first_q) ? first_q : last_q;
  assign len      = {1'b0, last_eff} - {1'b0, first_q} + 17'd1;
  assign diff     = now_q - deadline_q;

  always_comb begin
    tv = $signed({18'd0, td_q, 1'b0}) - $signed({{3{diff[31]}}, diff});
    if (tv <= 35'sd0) begin
      td_tick = '0;
    end else if (|tv[34:17]) begin
      td_tick = 16'hFFFF;
    end else begin
      td_tick = tv[16:1];
    end
  end

  assign s_f = DVD_W'(expected_q) + quot;
  assign s_e = {1'b0, frame_q} + 17'd1;

  assign el32 = now_q - last_up_q;
  assign el   = (|el32[31:16]) ? 16'hFFFF : el32[15:0];

  always_comb begin
    dwrap = 18'(frame_q) + 18'(len) - 18'(last_shown_q);
    if (frame_q >= last_shown_q) begin
      dval = frame_q - last_shown_q;
    end else if (dwrap[17]) begin
      dval = '0;
    end else begin
      dval = dwrap[15:0];
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.need_divn = drop_en_q && !diff[31] && (diff != 32'd0);
  assign sts_o.div_done  = div_done;
  assign sts_o.wrap_f    = s_f > DVD_W'(last_eff);
  assign sts_o.wrap_e    = s_e > {1'b0, last_eff};
  assign sts_o.adv_pos   = seen_q && (dval != 16'd0);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    if (cmd_i.decode && op_q == OP_TICK && sts_o.need_divn) begin
      div_start = 1'b1;
      div_dvd   = DVD_W'({diff, 1'b0}) + DVD_W'(iv_eff);
      div_dsr   = DSR_W'({iv_eff, 1'b0});
    end else if (cmd_i.n_done && sts_o.wrap_f) begin
      div_start = 1'b1;
      div_dvd   = s_f - DVD_W'(last_eff) - DVD_W'(1);
      div_dsr   = len;
    end else if (cmd_i.step_next && sts_o.wrap_e) begin
      div_start = 1'b1;
      div_dvd   = DVD_W'(frame_q - last_eff);
      div_dsr   = len;
    end else if (cmd_i.record && sts_o.adv_pos) begin
      div_start = 1'b1;
      div_dvd   = DVD_W'({el, 4'b0000});
      div_dsr   = {1'b0, dval};
    end
  end

  fps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .dvd_i  (div_dvd),
    .dsr_i  (div_dsr),
    .done_o (div_done),
    .quot_o (quot),
    .rem_o  (rem)
  );

  assign iv_we = cmd_i.record && seen_q;
  assign pf_we = cmd_i.pf_done;

  fps_ram #(.WIDTH(17), .DEPTH(WINDOW)) u_iv_ram (
    .clk_i  (clk_i),
    .we_i   (iv_we),
    .waddr_i(iv_ptr_q),
    .wdata_i({(dval != 16'd1), el}),
    .raddr_i(iv_ptr_q),
    .rdata_o(iv_rd)
  );

  fps_ram #(.WIDTH(20), .DEPTH(WINDOW)) u_pf_ram (
    .clk_i  (clk_i),
    .we_i   (pf_we),
    .waddr_i(pf_ptr_q),
    .wdata_i(quot[19:0]),
    .raddr_i(pf_ptr_q),
    .rdata_o(pf_rd)
  );

  assign iv_full  = iv_fill_q == FW'(WINDOW);
  assign pf_full  = pf_fill_q == FW'(WINDOW);
  assign old_el   = iv_full ? iv_rd[15:0] : 16'd0;
  assign old_drop = iv_full && iv_rd[16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q      <= 16'd0;
      last_q       <= 16'd100;
      ival_q       <= 10'd66;
      drop_en_q    <= 1'b1;
      op_q         <= OP_START;
      expected_q   <= '0;
      deadline_q   <= '0;
      td_q         <= '0;
      last_shown_q <= '0;
      last_up_q    <= '0;
      seen_q       <= 1'b0;
      iv_ptr_q     <= '0;
      pf_ptr_q     <= '0;
      iv_fill_q    <= '0;
      pf_fill_q    <= '0;
      isum_q       <= '0;
      dcnt_q       <= '0;
      psum_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FIRST:    first_q   <= cfg_wdata_i;
          REG_LAST:     last_q    <= cfg_wdata_i;
          REG_INTERVAL: ival_q    <= cfg_wdata_i[9:0];
          REG_DROP:     drop_en_q <= cfg_wdata_i[0];
          default:      first_q   <= first_q;
        endcase
      end
      if (cmd_i.capture) begin
        op_q <= op_i;
      end
      if (cmd_i.decode) begin
        case (op_q)
          OP_START: begin
            td_q         <= 16'(iv_eff);
            deadline_q   <= now_q + 32'(iv_eff);
            expected_q   <= first_q;
            last_shown_q <= first_q;
          end
          OP_TICK: begin
            td_q       <= td_tick;
            deadline_q <= now_q + 32'(iv_eff);
          end
          default: ;
        endcase
      end
      if (cmd_i.step_next && !sts_o.wrap_e) begin
        expected_q <= s_e[15:0];
      end
      if (cmd_i.mode_done) begin
        expected_q <= first_q + rem[15:0];
      end
      if (cmd_i.record) begin
        seen_q       <= 1'b1;
        last_up_q    <= now_q;
        last_shown_q <= frame_q;
        if (seen_q) begin
          isum_q   <= isum_q + IW'(el) - IW'(old_el);
          dcnt_q   <= dcnt_q + FW'(dval != 16'd1) - FW'(old_drop);
          iv_ptr_q <= (iv_ptr_q == AW'(WINDOW - 1)) ? '0 : iv_ptr_q + 1'b1;
          if (!iv_full) begin
            iv_fill_q <= iv_fill_q + 1'b1;
          end
        end
      end
      if (cmd_i.pf_done) begin
        psum_q   <= psum_q + PW'(quot[19:0]) - (pf_full ? PW'(pf_rd) : PW'(0));
        pf_ptr_q <= (pf_ptr_q == AW'(WINDOW - 1)) ? '0 : pf_ptr_q + 1'b1;
        if (!pf_full) begin
          pf_fill_q <= pf_fill_q + 1'b1;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q  <= now_ms_i;
      fnum_q <= frame_number_i;
    end
    if (cmd_i.decode) begin
      adv_q  <= '0;
      drop_q <= 1'b0;
      if (op_q == OP_SHOW) begin
        frame_q <= fnum_q;
      end else if (!sts_o.need_divn) begin
        frame_q <= expected_q;
      end
    end
    if (cmd_i.n_done && !sts_o.wrap_f) begin
      frame_q <= s_f[15:0];
    end
    if (cmd_i.modf_done) begin
      frame_q <= first_q + rem[15:0];
    end
    if (cmd_i.record && seen_q) begin
      adv_q  <= dval;
      drop_q <= dval != 16'd1;
    end
    if (cmd_i.load_out) begin
      o_shown_q <= last_shown_q;
      o_delay_q <= td_q;
      o_adv_q   <= adv_q;
      o_drop_q  <= drop_q;
      o_isum_q  <= isum_q;
      o_ifill_q <= iv_fill_q;
      o_dcnt_q  <= dcnt_q;
      o_psum_q  <= psum_q;
      o_pfill_q <= pf_fill_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign shown_frame_o     = o_shown_q;
  assign next_delay_ms_o   = o_delay_q;
  assign frames_advanced_o = o_adv_q;
  assign frame_dropped_o   = o_drop_q;
  assign interval_sum_o    = o_isum_q;
  assign interval_fill_o   = o_ifill_q;
  assign drop_count_o      = o_dcnt_q;
  assign per_frame_sum_o   = o_psum_q;
  assign per_frame_fill_o  = o_pfill_q;

endmodule

### rtl/fps_ctrl.sv
`timescale 1ns / 1ps
module fps_ctrl
  import fps_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_DIVN = 4'd2;
  localparam logic [3:0] S_MODF = 4'd3;
  localparam logic [3:0] S_NEXT = 4'd4;
  localparam logic [3:0] S_MODE = 4'd5;
  localparam logic [3:0] S_REC  = 4'd6;
  localparam logic [3:0] S_DIVP = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.decode = 1'b1;
        case (sts_i.op)
          OP_TICK: state_d = sts_i.need_divn ? S_DIVN : S_NEXT;
          OP_SHOW: state_d = S_REC;
          default: state_d = S_FIN;
        endcase
      end
      S_DIVN: begin
        if (sts_i.div_done) begin
          cmd_o.n_done = 1'b1;
          state_d      = sts_i.wrap_f ? S_MODF : S_NEXT;
        end
      end
      S_MODF: begin
        if (sts_i.div_done) begin
          cmd_o.modf_done = 1'b1;
          state_d         = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd_o.step_next = 1'b1;
        state_d         = sts_i.wrap_e ? S_MODE : S_REC;
      end
      S_MODE: begin
        if (sts_i.div_done) begin
          cmd_o.mode_done = 1'b1;
          state_d         = S_REC;
        end
      end
      S_REC: begin
        cmd_o.record = 1'b1;
        state_d      = sts_i.adv_pos ? S_DIVP : S_FIN;
      end
      S_DIVP: begin
        if (sts_i.div_done) begin
          cmd_o.pf_done = 1'b1;
          state_d       = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

### rtl/frame_pacing_scheduler_unit.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  op_i, now_ms_i, frame_number_i
// out      output     out_valid_o / out_stall_i  shown_frame_o ... per_frame_fill_o
// cfg      input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// Start and unused items pass through the decode and finish states only; a show item
// also records, and divides a per-frame sample when the shown frame has advanced. A tick
// makes up to four passes through the shared bit-serial divider.
// Reset clears all control state; ring contents are tracked by fill counts.
// A stalled result waits in the output register while the next item is taken.
module frame_pacing_scheduler_unit
  import fps_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF,
  localparam int unsigned FW = $clog2(WINDOW + 1),
  localparam int unsigned IW = 16 + FW,
  localparam int unsigned PW = 20 + FW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    op_i,
  input  logic [31:0]   now_ms_i,
  input  logic [15:0]   frame_number_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [15:0]   shown_frame_o,
  output logic [15:0]   next_delay_ms_o,
  output logic [15:0]   frames_advanced_o,
  output logic          frame_dropped_o,
  output logic [IW-1:0] interval_sum_o,
  output logic [FW-1:0] interval_fill_o,
  output logic [FW-1:0] drop_count_o,
  output logic [PW-1:0] per_frame_sum_o,
  output logic [FW-1:0] per_frame_fill_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  fps_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  fps_dp #(.WINDOW(WINDOW)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .op_i             (op_i),
    .now_ms_i         (now_ms_i),
    .frame_number_i   (frame_number_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .shown_frame_o    (shown_frame_o),
    .next_delay_ms_o  (next_delay_ms_o),
    .frames_advanced_o(frames_advanced_o),
    .frame_dropped_o  (frame_dropped_o),
    .interval_sum_o   (interval_sum_o),
    .interval_fill_o  (interval_fill_o),
    .drop_count_o     (drop_count_o),
    .per_frame_sum_o  (per_frame_sum_o),
    .per_frame_fill_o (per_frame_fill_o)
  );

`ifndef ASSERT_OFF
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> interval_fill_o <= FW'(WINDOW))
    else $error("interval fill beyond window");

  a_drop_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drop_count_o <= interval_fill_o)
    else $error("drop count exceeds interval fill");

  a_pf_le_iv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> per_frame_fill_o <= interval_fill_o)
    else $error("per-frame fill exceeds interval fill");

  a_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frames_advanced_o == 16'd1 |-> !frame_dropped_o)
    else $error("single-frame step flagged as dropped");
`endif

endmodule
